[src/sdas_pkg.sv]
`timescale 1ns / 1ps

package sdas_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned BCD_W   = 4 * DIGITS;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    // commands from the sequencer to the converter
    typedef struct packed {
        logic start;
        logic shift_digit;
    } sdas_cmd_t;

    // converter status back to the sequencer
    typedef struct packed {
        logic       done;
        logic [3:0] top_digit;
    } sdas_stat_t;

endpackage

[src/sdas_dabble.sv]
`timescale 1ns / 1ps

module sdas_dabble
    import sdas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sdas_cmd_t          cmd,
    input  logic [VALUE_W-1:0] mag,
    output sdas_stat_t         stat
);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [BCD_W-1:0]   bcd_adj;

    function automatic logic [3:0] add3(input logic [3:0] d);
        add3 = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = add3(bcd_reg[4*i +: 4]);
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = 6'(VALUE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one add-3 pass and one shift per bit, MSB first
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (cmd.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.done      = done_reg;
    assign stat.top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

[src/signed_int_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps
// After accept, the converter runs its conversion, then emits the sign word
// (negative values only), the 10 digit positions in turn (leading zeros are
// skipped without output) and last the newline word. Output stalls hold
// the flow; a new value is taken only after the closing newline is issued.
// rst_n is asynchronous, active low, and clears all control state.

module signed_int_to_decimal_ascii_core
    import sdas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     value_valid,
    output logic                     value_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [CHAR_W-1:0]        character,
    output logic                     last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGIT,
        S_NL
    } state_t;

    state_t             state_reg, state_next;
    logic               neg_reg, neg_next;
    logic               started_reg, started_next;
    logic [3:0]         left_reg, left_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    sdas_cmd_t          cmd;
    sdas_stat_t         stat;
    logic [VALUE_W-1:0] mag;
    logic               out_free;
    logic               emit;

    assign value_ready = (state_reg == S_IDLE);
    assign mag = value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
    assign out_free = !valid_reg || result_ready;

    sdas_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .mag   (mag),
        .stat  (stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        started_next     = started_reg;
        left_next        = left_reg;
        char_next        = char_reg;
        last_next        = last_reg;
        emit             = 1'b0;
        cmd.start        = 1'b0;
        cmd.shift_digit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (value_valid)
                begin
                    neg_next   = value[VALUE_W-1];
                    cmd.start  = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (stat.done)
                begin
                    left_next    = 4'(DIGITS);
                    started_next = 1'b0;
                    state_next   = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    char_next  = CH_MINUS;
                    last_next  = 1'b0;
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (!started_reg && stat.top_digit == 4'd0 && left_reg != 4'd1)
                begin
                    // leading zero
                    cmd.shift_digit = 1'b1;
                    left_next       = left_reg - 4'd1;
                end
                else if (out_free)
                begin
                    emit            = 1'b1;
                    char_next       = CH_ZERO + CHAR_W'(stat.top_digit);
                    last_next       = 1'b0;
                    started_next    = 1'b1;
                    cmd.shift_digit = 1'b1;
                    left_next       = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        state_next = S_NL;
                    end
                end
            end
            S_NL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    char_next  = CH_NEWLINE;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            left_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            left_reg    <= left_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign result_valid = valid_reg;
    assign character    = char_reg;
    assign last         = last_reg;

endmodule

[tb/decimal_text_checker.sv]
`timescale 1ns / 1ps

module decimal_text_checker
    import sdas_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      value_valid,
    input  logic                      value_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  logic [CHAR_W-1:0]         character,
    input  logic                      last,
    output int                        fail_count,
    output int                        pending,
    output int                        values_seen,
    output int                        negatives_seen,
    output int                        chars_seen
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];

    // queue the characters of the decimal text of v
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit [DIGITS];
        int                 nd;
        text_char_t         c;
        nd  = 0;
        mag = v[VALUE_W-1] ? (~v + 32'd1) : v;
        do
        begin
            digit[nd] = 4'(mag % 32'd10);
            mag       = mag / 32'd10;
            nd++;
        end
        while (mag != 0);
        if (v[VALUE_W-1])
        begin
            c.ch   = CH_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            c.ch   = CH_ZERO + CHAR_W'(digit[i]);
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        c.ch   = CH_NEWLINE;
        c.last = 1'b1;
        expected_text.push_back(c);
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            expected_text.delete();
            fail_count     = 0;
            pending        = 0;
            values_seen    = 0;
            negatives_seen = 0;
            chars_seen     = 0;
        end
        else
        begin
            if (value_valid && value_ready)
            begin
                predict_text(value);
                values_seen++;
                if (value[VALUE_W-1])
                    negatives_seen++;
            end
            if (result_valid && result_ready)
            begin
                chars_seen++;
                if (expected_text.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word: character=%0d last=%0b",
                             $time, character, last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.ch)
                    begin
                        fail_count++;
                        $display("%0t: character mismatch: expected %0d actual %0d",
                                 $time, want.ch, character);
                    end
                    if (last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last mismatch: expected %0b actual %0b",
                                 $time, want.last, last);
                    end
                end
            end
            pending = expected_text.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sdas_pkg::*;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      value_valid  = 1'b0;
    logic                      value_ready;
    logic signed [VALUE_W-1:0] value        = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    logic [CHAR_W-1:0]         character;
    logic                      last;

    int fail_count;
    int pending;
    int values_seen;
    int negatives_seen;
    int chars_seen;

    int send_idle_pct = 28;
    int recv_idle_pct = 73;

    logic [VALUE_W-1:0] directed [21] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99,
        32'd100, 32'd999999999, 32'd1000000000, -32'sd1000000000,
        32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'd12345,
        -32'sd54321, 32'h5555_5555, 32'haaaa_aaaa, 32'd1234567890,
        -32'sd999999999
    };

    always #10 clk = ~clk;

    signed_int_to_decimal_ascii_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_valid  (value_valid),
        .value_ready  (value_ready),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .character    (character),
        .last         (last)
    );

    decimal_text_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .value_valid    (value_valid),
        .value_ready    (value_ready),
        .value          (value),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .character      (character),
        .last           (last),
        .fail_count     (fail_count),
        .pending        (pending),
        .values_seen    (values_seen),
        .negatives_seen (negatives_seen),
        .chars_seen     (chars_seen)
    );

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            value_valid <= 1'b0;
            value       <= $urandom();
        end
        @(negedge clk);
        value_valid <= 1'b1;
        value       <= v;
        do
            @(posedge clk);
        while (!value_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        value_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // mix of full-range words, random digit counts, powers of ten and extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned p;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        int              d;
        logic [VALUE_W-1:0] r;
        case ($urandom_range(3))
            0: r = $urandom();
            1:
            begin
                d = $urandom_range(1, 10);
                p = 1;
                repeat (d - 1) p = p * 10;
                lo = (d == 1) ? 0 : p;
                hi = p * 10 - 1;
                if (hi > 64'd2147483648)
                    hi = 64'd2147483648;
                mag = lo + (longint'($urandom()) % (hi - lo + 1));
                r = mag[VALUE_W-1:0];
                if ($urandom_range(1))
                    r = -r;
            end
            2:
            begin
                p = 1;
                repeat ($urandom_range(9)) p = p * 10;
                mag = p + $urandom_range(2) - 1;
                r = mag[VALUE_W-1:0];
                if ($urandom_range(1))
                    r = -r;
            end
            default:
            begin
                case ($urandom_range(5))
                    0: r = 32'h0000_0000;
                    1: r = 32'h7fff_ffff;
                    2: r = 32'h8000_0000;
                    3: r = 32'h8000_0001;
                    4: r = 32'hffff_ffff;
                    default: r = 32'h0000_0001;
                endcase
            end
        endcase
        return r;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_value(directed[i]);
        repeat (110) send_value(pick_value());
        drain();

        send_idle_pct = 73;
        recv_idle_pct = 28;
        repeat (120) send_value(pick_value());
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (120) send_value(pick_value());
        drain();

        repeat (80) @(negedge clk);
        $display("covered %0d values (%0d negative), %0d characters checked",
                 values_seen, negatives_seen, chars_seen);
        $display("idle mixes: sender 28/receiver 73, sender 73/receiver 28, none");
        if (fail_count == 0)
            $display("signed_int_to_decimal_ascii_core regression: pass");
        else
            $display("signed_int_to_decimal_ascii_core regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d words outstanding", pending);
        $display("signed_int_to_decimal_ascii_core regression: fail");
        $finish;
    end

endmodule

[filelist.f]
src/sdas_pkg.sv
src/sdas_dabble.sv
src/signed_int_to_decimal_ascii_core.sv
tb/decimal_text_checker.sv
tb/tb.sv
